### rtl/mlpte_pkg.sv
// package for the multilevel page table engine: sizes, codes and shared types
package mlpte_pkg;
	localparam int OFFSET_BITS = 12;
	localparam int LEVEL_COUNT = 4;
	localparam int FRAME_COUNT = 256;
	localparam int LVL_BITS = OFFSET_BITS - 3;
	localparam int TBL_ENTRIES = 1 << LVL_BITS;
	localparam int FRAME_W = $clog2(FRAME_COUNT + 1);
	localparam int SLOT_W = $clog2(FRAME_COUNT) + LVL_BITS;
	localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam int ENTRY_W = 10;
	localparam int VA_W = 48;
	localparam int PA_W = 21;

	localparam logic [1:0] KIND_TRANSLATE = 2'd0;
	localparam logic [1:0] KIND_MAP = 2'd1;
	localparam logic [1:0] KIND_UNMAP = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_NO_FRAMES = 2'd2;

	// request from the sequencer to the entry memory
	typedef struct packed {
		logic rd;
		logic wr;
		logic [SLOT_W-1:0] addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	// frame pool commands and answers
	typedef struct packed {
		logic take;
		logic free;
		logic [FRAME_W-1:0] free_frame;
	} pool_req_t;

	typedef struct packed {
		logic found;
		logic [FRAME_W-1:0] frame;
	} pool_rsp_t;

	// level index of a virtual address, zero where the shift leaves 64 bits
	function automatic logic [LVL_BITS-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [LVL_W-1:0] lvl);
		logic [63:0] wide;
		int sh;
		sh = OFFSET_BITS + int'(lvl) * LVL_BITS;
		wide = {{(64-VA_W){1'b0}}, va};
		if (sh >= 64) begin
			return '0;
		end
		return LVL_BITS'(wide >> sh);
	endfunction

	// frame number of an entry, zero when not valid or out of range
	function automatic logic [FRAME_W-1:0] entry_frame(input logic [ENTRY_W-1:0] e);
		logic [ENTRY_W-2:0] f;
		f = e[ENTRY_W-1:1];
		if (!e[0] || f == '0 || int'(f) > FRAME_COUNT) begin
			return '0;
		end
		return FRAME_W'(f);
	endfunction
endpackage

### rtl/mlpte_entry_ram.sv
// entry store: single port memory with registered read data
module mlpte_entry_ram
	import mlpte_pkg::*;
(
	input  logic clk,
	input  mem_req_t req,
	output logic [ENTRY_W-1:0] rdata
);
	logic [ENTRY_W-1:0] mem [FRAME_COUNT*TBL_ENTRIES];

	// one access a cycle
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end else if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end
endmodule

### rtl/mlpte_frame_pool.sv
// frame pool: in-use bits with a lowest free frame search
module mlpte_frame_pool
	import mlpte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  pool_req_t req,
	output pool_rsp_t rsp
);
	logic [FRAME_COUNT-1:0] in_use_q;
	logic [FRAME_COUNT-1:0] low_free;
	logic [FRAME_W-1:0] free_m1;
	logic [SLOT_W-LVL_BITS-1:0] free_idx;

	// lowest free frame, one-hot, via carry chain
	assign low_free = ~in_use_q & (in_use_q + 1'b1);

	// bit position of the frame being released
	assign free_m1 = req.free_frame - 1'b1;
	assign free_idx = free_m1[SLOT_W-LVL_BITS-1:0];

	always_comb begin
		rsp.found = |low_free;
		rsp.frame = '0;
		for (int i = 0; i < FRAME_COUNT; i++) begin
			if (low_free[i]) begin
				rsp.frame = FRAME_W'(i + 1);
			end
		end
	end

	// update in-use bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else begin
			if (req.take) begin
				in_use_q <= in_use_q | low_free;
			end else if (req.free && req.free_frame != '0
					&& int'(req.free_frame) <= FRAME_COUNT) begin
				in_use_q[free_idx] <= 1'b0;
			end
		end
	end
endmodule

### rtl/mlpte_walker.sv
// walk sequencer: translate, map and unmap through the entry memory
module mlpte_walker
	import mlpte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	output logic ready_in,
	input  logic [1:0] kind,
	input  logic [VA_W-1:0] vaddr,
	output logic valid_out,
	input  logic ready_out,
	output logic [PA_W-1:0] phys_addr,
	output logic [1:0] status,
	output mem_req_t mreq,
	input  logic [ENTRY_W-1:0] rdata,
	output pool_req_t preq,
	input  pool_rsp_t prsp
);
	typedef enum logic [3:0] {
		IDLE, READ, WAIT, CHECK, TAKE, CLEAR, LINK, UNLEAF, SCAN, SCAN_WAIT,
		SCAN_CHK, UNLINK, DONE
	} state_t;

	state_t state_q;
	logic [1:0] kind_q;
	logic [VA_W-1:0] va_q;
	logic [FRAME_W-1:0] root_q, cur_q, new_q;
	logic [LVL_W-1:0] lvl_q;
	logic [FRAME_W-1:0] tbl_q [LEVEL_COUNT];
	logic [LVL_BITS-1:0] cnt_q;
	logic [1:0] stat_q;
	logic [PA_W-1:0] pa_q;
	logic [LVL_BITS-1:0] idx;
	logic [FRAME_W-1:0] ef;

	assign idx = level_index(va_q, lvl_q);
	assign ef = entry_frame(rdata);
	assign ready_in = (state_q == IDLE);
	assign valid_out = (state_q == DONE);
	assign phys_addr = pa_q;
	assign status = stat_q;

	function automatic logic [SLOT_W-1:0] slot(input logic [FRAME_W-1:0] f,
			input logic [LVL_BITS-1:0] i);
		logic [FRAME_W-1:0] fm;
		fm = f - 1'b1;
		return {fm[SLOT_W-LVL_BITS-1:0], i};
	endfunction

	// memory and pool requests by state
	always_comb begin
		mreq = '0;
		preq = '0;
		unique case (state_q)
			READ: begin
				mreq.rd = 1'b1;
				mreq.addr = slot(cur_q, idx);
			end
			TAKE: preq.take = prsp.found;
			CLEAR: begin
				mreq.wr = 1'b1;
				mreq.addr = slot(new_q, cnt_q);
			end
			LINK: begin
				mreq.wr = (cur_q != '0);
				mreq.addr = slot(cur_q, idx);
				mreq.wdata = {new_q[ENTRY_W-2:0], 1'b1};
			end
			UNLEAF: begin
				mreq.wr = 1'b1;
				mreq.addr = slot(tbl_q[0], level_index(va_q, '0));
				preq.free = 1'b1;
				preq.free_frame = cur_q;
			end
			SCAN: begin
				mreq.rd = 1'b1;
				mreq.addr = slot(tbl_q[lvl_q - 1'b1], cnt_q);
			end
			UNLINK: begin
				mreq.wr = 1'b1;
				mreq.addr = slot(tbl_q[lvl_q], idx);
				preq.free = 1'b1;
				preq.free_frame = tbl_q[lvl_q - 1'b1];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			root_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (valid_in) begin
					kind_q <= kind;
					va_q <= vaddr;
					lvl_q <= LVL_W'(LEVEL_COUNT - 1);
					cur_q <= root_q;
					pa_q <= '0;
					stat_q <= ST_OK;
					if (kind == KIND_MAP) begin
						state_q <= (root_q == '0) ? TAKE : READ;
					end else if ((kind == KIND_TRANSLATE || kind == KIND_UNMAP)
							&& root_q != '0) begin
						state_q <= READ;
					end else begin
						stat_q <= ST_UNMAPPED;
						state_q <= DONE;
					end
				end
				READ: begin
					tbl_q[lvl_q] <= cur_q;
					state_q <= WAIT;
				end
				WAIT: state_q <= CHECK;
				CHECK: begin
					if (ef == '0) begin
						if (kind_q == KIND_MAP) begin
							state_q <= TAKE;
						end else begin
							stat_q <= ST_UNMAPPED;
							state_q <= DONE;
						end
					end else begin
						cur_q <= ef;
						if (lvl_q == '0) begin
							if (kind_q == KIND_TRANSLATE) begin
								pa_q <= PA_W'({ef, va_q[OFFSET_BITS-1:0]});
								state_q <= DONE;
							end else if (kind_q == KIND_UNMAP) begin
								state_q <= UNLEAF;
							end else begin
								state_q <= DONE;
							end
						end else begin
							lvl_q <= lvl_q - 1'b1;
							state_q <= READ;
						end
					end
				end
				TAKE: begin
					if (!prsp.found) begin
						stat_q <= ST_NO_FRAMES;
						state_q <= DONE;
					end else begin
						new_q <= prsp.frame;
						cnt_q <= '0;
						state_q <= CLEAR;
					end
				end
				CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LVL_BITS'(TBL_ENTRIES - 1)) begin
						state_q <= LINK;
					end
				end
				LINK: begin
					if (cur_q == '0) begin
						root_q <= new_q;
						cur_q <= new_q;
						state_q <= READ;
					end else begin
						cur_q <= new_q;
						if (lvl_q == '0) begin
							state_q <= DONE;
						end else begin
							lvl_q <= lvl_q - 1'b1;
							state_q <= READ;
						end
					end
				end
				UNLEAF: begin
					lvl_q <= LVL_W'(1);
					cnt_q <= '0;
					state_q <= (LEVEL_COUNT > 1) ? SCAN : DONE;
				end
				SCAN: state_q <= SCAN_WAIT;
				SCAN_WAIT: state_q <= SCAN_CHK;
				SCAN_CHK: begin
					if (ef != '0) begin
						state_q <= DONE;
					end else if (cnt_q == LVL_BITS'(TBL_ENTRIES - 1)) begin
						state_q <= UNLINK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= SCAN;
					end
				end
				UNLINK: begin
					cnt_q <= '0;
					if (int'(lvl_q) == LEVEL_COUNT - 1) begin
						state_q <= DONE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
						state_q <= SCAN;
					end
				end
				DONE: if (ready_out) begin
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### rtl/multilevel_page_table_engine_top.sv
// top level of the multilevel page table engine
// One word in, one word out; the block takes one request at a time. A translate
// reads, waits and checks at each level through the single entry memory port,
// after it accepts the word and before it presents the result; a map adds the
// steps pick, clear (all 2^(OFFSET_BITS-3) entries) and link for each table or
// page it takes; an unmap adds a step to clear the leaf entry, then an emptiness
// scan that reads each entry in turn and frees each table found empty, climbing
// level by level and stopping at the first entry still in use.
module multilevel_page_table_engine_top
	import mlpte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	output logic ready_in,
	input  logic [1:0] kind,
	input  logic [VA_W-1:0] vaddr,
	output logic valid_out,
	input  logic ready_out,
	output logic [PA_W-1:0] phys_addr,
	output logic [1:0] status
);
	mem_req_t mreq;
	logic [ENTRY_W-1:0] rdata;
	pool_req_t preq;
	pool_rsp_t prsp;

	// sequencer
	mlpte_walker u_walker (
		.clk(clk), .arst_n(arst_n), .valid_in(valid_in), .ready_in(ready_in),
		.kind(kind), .vaddr(vaddr), .valid_out(valid_out),
		.ready_out(ready_out), .phys_addr(phys_addr), .status(status),
		.mreq(mreq), .rdata(rdata), .preq(preq), .prsp(prsp)
	);

	// entry memory
	mlpte_entry_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

	// frame pool
	mlpte_frame_pool u_pool (.clk(clk), .arst_n(arst_n), .req(preq), .rsp(prsp));
endmodule
